[rtl/sobb_pkg.sv]
package sobb_pkg;

  localparam int ROT_W     = 16;
  localparam int AXIS_W    = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 3'd6;

  localparam logic [AXIS_W-1:0] AXIS_X_RST = 48'h0000_0000_4000;
  localparam logic [AXIS_W-1:0] AXIS_Y_RST = 48'h0000_4000_0000;
  localparam logic [AXIS_W-1:0] AXIS_Z_RST = 48'h4000_0000_0000;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef rot_t [2:0][2:0] rot_mat_t;

  typedef struct packed {
    logic valid;
    logic outside;
    logic big;
  } sobb_ctl_t;

endpackage

[rtl/sobb_if.sv]
interface sobb_in_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sphere_x;
  logic signed [COORD_BITS-1:0] sphere_y;
  logic signed [COORD_BITS-1:0] sphere_z;
  logic        [COORD_BITS-2:0] sphere_radius;

  modport source(output valid, sphere_x, sphere_y, sphere_z, sphere_radius, input ready);
  modport sink(input valid, sphere_x, sphere_y, sphere_z, sphere_radius, output ready);
endinterface

interface sobb_out_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source(output valid, overlaps, input ready);
  modport sink(input valid, overlaps, output ready);
endinterface

[rtl/sobb_cfg.sv]
module sobb_cfg #(
  parameter int COORD_BITS = 20,
  parameter int CFG_W      = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sobb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [CFG_W-1:0]                    cfg_data,
  output logic signed [COORD_BITS-1:0]        center_x,
  output logic signed [COORD_BITS-1:0]        center_y,
  output logic signed [COORD_BITS-1:0]        center_z,
  output logic [3*COORD_BITS-1:0]             extents,
  output sobb_pkg::rot_mat_t                  rot
);

  localparam int EXT_W = 3 * COORD_BITS;

  logic signed [COORD_BITS-1:0]     cx_r, cy_r, cz_r;
  logic [EXT_W-1:0]                 ext_r;
  logic [EXT_W-1:0]                 ext_mask;
  logic [sobb_pkg::AXIS_W-1:0]      axis_r [3];

  for (genvar k = 0; k < EXT_W; k++) begin : g_mask
    assign ext_mask[k] = (k < 64) ? 1'b1 : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= '0;
      cy_r      <= '0;
      cz_r      <= '0;
      ext_r     <= '0;
      axis_r[0] <= sobb_pkg::AXIS_X_RST;
      axis_r[1] <= sobb_pkg::AXIS_Y_RST;
      axis_r[2] <= sobb_pkg::AXIS_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sobb_pkg::CFG_CENTER_X: cx_r      <= $signed(cfg_data[COORD_BITS-1:0]);
        sobb_pkg::CFG_CENTER_Y: cy_r      <= $signed(cfg_data[COORD_BITS-1:0]);
        sobb_pkg::CFG_CENTER_Z: cz_r      <= $signed(cfg_data[COORD_BITS-1:0]);
        sobb_pkg::CFG_EXTENTS:  ext_r     <= cfg_data[EXT_W-1:0] & ext_mask;
        sobb_pkg::CFG_AXIS_X:   axis_r[0] <= cfg_data[sobb_pkg::AXIS_W-1:0];
        sobb_pkg::CFG_AXIS_Y:   axis_r[1] <= cfg_data[sobb_pkg::AXIS_W-1:0];
        sobb_pkg::CFG_AXIS_Z:   axis_r[2] <= cfg_data[sobb_pkg::AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rot[r][c] = axis_r[c][16*r +: 16];
      end
    end
  end

  assign center_x = cx_r;
  assign center_y = cy_r;
  assign center_z = cz_r;
  assign extents  = ext_r;

endmodule

[rtl/sobb_fwd.sv]
module sobb_fwd #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [COORD_BITS-1:0]        sphere_x,
  input  logic signed [COORD_BITS-1:0]        sphere_y,
  input  logic signed [COORD_BITS-1:0]        sphere_z,
  input  logic        [COORD_BITS-2:0]        sphere_radius,
  input  logic signed [COORD_BITS-1:0]        center_x,
  input  logic signed [COORD_BITS-1:0]        center_y,
  input  logic signed [COORD_BITS-1:0]        center_z,
  input  logic [3*COORD_BITS-1:0]             extents,
  input  sobb_pkg::rot_mat_t                  rot,
  output sobb_pkg::sobb_ctl_t                 ctl,
  output logic signed [COORD_BITS+14:0]       q [3],
  output logic signed [COORD_BITS:0]          d [3],
  output logic        [COORD_BITS-2:0]        radius
);

  localparam int DW  = COORD_BITS + 1;
  localparam int P1W = COORD_BITS + 17;
  localparam int S1W = COORD_BITS + 19;
  localparam int QW  = COORD_BITS + 15;
  localparam int RW  = COORD_BITS - 1;

  logic                   v1_r, v2_r;
  sobb_pkg::sobb_ctl_t    ctl3_r;
  logic signed [DW-1:0]   d1_nxt [3];
  logic signed [DW-1:0]   d1_r [3], d2_r [3], d3_r [3];
  logic [RW-1:0]          r1_r, r2_r, r3_r;
  logic signed [P1W-1:0]  p_nxt [3][3];
  logic signed [P1W-1:0]  p_r [3][3];
  logic signed [S1W-1:0]  acc [3];
  logic signed [S1W-1:0]  lim [3];
  logic signed [QW-1:0]   q_nxt [3];
  logic signed [QW-1:0]   q_r [3];
  logic [2:0]             clip;

  assign d1_nxt[0] = DW'(sphere_x) - DW'(center_x);
  assign d1_nxt[1] = DW'(sphere_y) - DW'(center_y);
  assign d1_nxt[2] = DW'(sphere_z) - DW'(center_z);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        p_nxt[j][i] = P1W'($signed(rot[i][j])) * P1W'(d1_r[i]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j]  = S1W'(p_r[j][0]) + S1W'(p_r[j][1]) + S1W'(p_r[j][2]);
      lim[j]  = $signed(S1W'({extents[j*COORD_BITS +: COORD_BITS], 14'b0}));
      clip[j] = 1'b1;
      if (acc[j] < -lim[j]) begin
        q_nxt[j] = QW'(-lim[j]);
      end else if (acc[j] > lim[j]) begin
        q_nxt[j] = QW'(lim[j]);
      end else begin
        q_nxt[j] = QW'(acc[j]);
        clip[j]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r           <= in_valid;
      v2_r           <= v1_r;
      ctl3_r.valid   <= v2_r;
      ctl3_r.outside <= |clip;
      ctl3_r.big     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d1_nxt;
      r1_r <= sphere_radius;
      p_r  <= p_nxt;
      d2_r <= d1_r;
      r2_r <= r1_r;
      q_r  <= q_nxt;
      d3_r <= d2_r;
      r3_r <= r2_r;
    end
  end

  assign ctl    = ctl3_r;
  assign q      = q_r;
  assign d      = d3_r;
  assign radius = r3_r;

endmodule

[rtl/sobb_back.sv]
module sobb_back #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  sobb_pkg::sobb_ctl_t                 ctl_in,
  input  logic signed [COORD_BITS+14:0]       q [3],
  input  logic signed [COORD_BITS:0]          d [3],
  input  logic        [COORD_BITS-2:0]        radius,
  input  sobb_pkg::rot_mat_t                  rot,
  output sobb_pkg::sobb_ctl_t                 ctl_out,
  output logic [2*COORD_BITS-3:0]             sq [3],
  output logic [2*COORD_BITS-3:0]             r2
);

  localparam int DW  = COORD_BITS + 1;
  localparam int QW  = COORD_BITS + 15;
  localparam int P2W = QW + 16;
  localparam int S2W = COORD_BITS + 33;
  localparam int BW  = S2W - 28;
  localparam int EW  = COORD_BITS + 6;
  localparam int RW  = COORD_BITS - 1;
  localparam int SQW = 2 * RW;
  localparam logic signed [S2W-1:0] HALF = S2W'(64'sd134217728);

  sobb_pkg::sobb_ctl_t    c4_r, c5_r, c6_r, c7_r;
  logic signed [P2W-1:0]  p_nxt [3][3];
  logic signed [P2W-1:0]  p_r [3][3];
  logic signed [DW-1:0]   d4_r [3], d5_r [3];
  logic [RW-1:0]          r4_r, r5_r, r6_r;
  logic signed [S2W-1:0]  rsum [3];
  logic signed [BW-1:0]   bk_nxt [3];
  logic signed [BW-1:0]   bk_r [3];
  logic signed [EW-1:0]   e [3];
  logic [EW-1:0]          m [3];
  logic [2:0]             over;
  logic [RW-1:0]          m_nxt [3];
  logic [RW-1:0]          m_r [3];
  logic [SQW-1:0]         sq_nxt [3];
  logic [SQW-1:0]         sq_r [3];
  logic [SQW-1:0]         r2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_nxt[i][j] = P2W'($signed(rot[i][j])) * P2W'(q[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i]   = S2W'(p_r[i][0]) + S2W'(p_r[i][1]) + S2W'(p_r[i][2]) + HALF;
      bk_nxt[i] = $signed(rsum[i][S2W-1:28]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i]     = EW'(d5_r[i]) - EW'(bk_r[i]);
      m[i]     = e[i][EW-1] ? EW'(-e[i]) : EW'(e[i]);
      over[i]  = m[i] > EW'(r5_r);
      m_nxt[i] = m[i][RW-1:0];
      sq_nxt[i] = SQW'(m_r[i]) * SQW'(m_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
    end else if (en) begin
      c4_r         <= ctl_in;
      c5_r         <= c4_r;
      c6_r.valid   <= c5_r.valid;
      c6_r.outside <= c5_r.outside;
      c6_r.big     <= |over;
      c7_r         <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      d4_r <= d;
      r4_r <= radius;
      bk_r <= bk_nxt;
      d5_r <= d4_r;
      r5_r <= r4_r;
      m_r  <= m_nxt;
      r6_r <= r5_r;
      sq_r <= sq_nxt;
      r2_r <= SQW'(r6_r) * SQW'(r6_r);
    end
  end

  assign ctl_out = c7_r;
  assign sq      = sq_r;
  assign r2      = r2_r;

endmodule

[rtl/sphere_obb_overlap_test_top.sv]
// Channel   Dir  Payload                                     Transfer when
// in_if     in   sphere_x/y/z, sphere_radius                 valid && ready
// out_if    out  overlaps                                    valid && ready
// cfg_*     in   cfg_idx, cfg_data                           cfg_we
//
// One sphere per cycle while no result is held; each result passes
// through the eight-stage chain: offset, forward multiply, clamp, back
// multiply, round, error magnitude, square, final compare.
// Reset clears all valid bits and loads the box registers (identity axes).
// A held result stalls every stage at once; nothing is lost or repeated.
module sphere_obb_overlap_test_top #(
  parameter int COORD_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sobb_in_if.sink                           in_if,
  sobb_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [sobb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [((3*COORD_BITS > 48) ? 3*COORD_BITS : 48)-1:0] cfg_data
);

  localparam int CFG_W = (3 * COORD_BITS > 48) ? 3 * COORD_BITS : 48;
  localparam int QW    = COORD_BITS + 15;
  localparam int DW    = COORD_BITS + 1;
  localparam int RW    = COORD_BITS - 1;
  localparam int SQW   = 2 * RW;
  localparam int SUMW  = SQW + 2;

  logic signed [COORD_BITS-1:0]  center_x, center_y, center_z;
  logic [3*COORD_BITS-1:0]       extents;
  sobb_pkg::rot_mat_t            rot;
  logic                          en;
  sobb_pkg::sobb_ctl_t           fwd_ctl, back_ctl;
  logic signed [QW-1:0]          q [3];
  logic signed [DW-1:0]          d [3];
  logic [RW-1:0]                 radius;
  logic [SQW-1:0]                sq [3];
  logic [SQW-1:0]                r2;
  logic [SUMW-1:0]               dist2;
  logic                          out_valid_r, overlaps_r, overlaps_nxt;

  sobb_cfg #(
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .extents  (extents),
    .rot      (rot)
  );

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  sobb_fwd #(
    .COORD_BITS (COORD_BITS)
  ) u_fwd (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_if.valid),
    .sphere_x      (in_if.sphere_x),
    .sphere_y      (in_if.sphere_y),
    .sphere_z      (in_if.sphere_z),
    .sphere_radius (in_if.sphere_radius),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .extents       (extents),
    .rot           (rot),
    .ctl           (fwd_ctl),
    .q             (q),
    .d             (d),
    .radius        (radius)
  );

  sobb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (fwd_ctl),
    .q       (q),
    .d       (d),
    .radius  (radius),
    .rot     (rot),
    .ctl_out (back_ctl),
    .sq      (sq),
    .r2      (r2)
  );

  assign dist2        = SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
  assign overlaps_nxt = !back_ctl.outside || (!back_ctl.big && (dist2 <= SUMW'(r2)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= back_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlaps_r <= overlaps_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.overlaps = overlaps_r;

endmodule

[rtl/sobb_chk.sv]
module sobb_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overlaps
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(overlaps))
    else $error("held result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind sphere_obb_overlap_test_top sobb_chk u_sobb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .overlaps  (out_if.overlaps)
);

[test/sphere_obb_overlap_test_top_test.sv]
module sphere_obb_overlap_test_top_test;

  localparam int COORD_BITS  = 20;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int CFG_W       = 60;
  localparam int COORD_MAX   = 524287;
  localparam int COORD_MIN   = -524288;
  localparam int RADIUS_MAX  = 524287;
  localparam int LATENCY     = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 163;

  localparam logic [sobb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {AXES_IDENTITY, AXES_PERMUTED, AXES_PERTURBED, AXES_RANDOM} axes_mode_e;
  typedef enum int {EXT_RANDOM, EXT_ZERO, EXT_FULL} ext_mode_e;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic        [COORD_BITS-2:0] radius;
  } sphere_t;

  class overlap_scoreboard;
    longint          box_center[3];
    logic [CFG_W-1:0] box_ext;
    logic [sobb_pkg::AXIS_W-1:0] box_axis[3];
    bit              overlap_q[$];
    int              errors;

    function new();
      box_center[0] = 0;
      box_center[1] = 0;
      box_center[2] = 0;
      box_ext       = '0;
      box_axis[0]   = sobb_pkg::AXIS_X_RST;
      box_axis[1]   = sobb_pkg::AXIS_Y_RST;
      box_axis[2]   = sobb_pkg::AXIS_Z_RST;
      errors        = 0;
    endfunction

    function void write_reg(logic [sobb_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        sobb_pkg::CFG_CENTER_X: box_center[0] = longint'($signed(value[COORD_BITS-1:0]));
        sobb_pkg::CFG_CENTER_Y: box_center[1] = longint'($signed(value[COORD_BITS-1:0]));
        sobb_pkg::CFG_CENTER_Z: box_center[2] = longint'($signed(value[COORD_BITS-1:0]));
        sobb_pkg::CFG_EXTENTS:  box_ext       = value;
        sobb_pkg::CFG_AXIS_X:   box_axis[0]   = value[sobb_pkg::AXIS_W-1:0];
        sobb_pkg::CFG_AXIS_Y:   box_axis[1]   = value[sobb_pkg::AXIS_W-1:0];
        sobb_pkg::CFG_AXIS_Z:   box_axis[2]   = value[sobb_pkg::AXIS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint axis_entry(int row, int col);
      sobb_pkg::rot_t e;
      e = box_axis[col][sobb_pkg::ROT_W*row +: sobb_pkg::ROT_W];
      return longint'(e);
    endfunction

    function bit predict_overlap(sphere_t s);
      longint d[3];
      longint q[3];
      longint acc, ext, back, e, m, r, sumsq;
      bit     outside;
      outside = 1'b0;
      d[0] = longint'(s.x) - box_center[0];
      d[1] = longint'(s.y) - box_center[1];
      d[2] = longint'(s.z) - box_center[2];
      r = longint'(s.radius);
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        ext = longint'(box_ext[COORD_BITS*j +: COORD_BITS]) << 14;
        for (int i = 0; i < 3; i++) acc += axis_entry(i, j) * d[i];
        if (acc < -ext) begin
          acc = -ext;
          outside = 1'b1;
        end else if (acc > ext) begin
          acc = ext;
          outside = 1'b1;
        end
        q[j] = acc;
      end
      if (!outside) return 1'b1;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += axis_entry(i, j) * q[j];
        back = (acc + (longint'(1) << 27)) >>> 28;
        e = d[i] - back;
        m = (e < 0) ? -e : e;
        if (m > r) return 1'b0;
        sumsq += m * m;
      end
      return (sumsq > r * r) ? 1'b0 : 1'b1;
    endfunction

    function void note_sphere(sphere_t s);
      overlap_q.push_back(predict_overlap(s));
    endfunction

    function void check_result(logic got);
      bit exp_bit;
      if (overlap_q.size() == 0) begin
        $error("overlaps: unexpected transfer, got %0d", got);
        errors++;
        return;
      end
      exp_bit = overlap_q.pop_front();
      if (got !== exp_bit) begin
        $error("overlaps mismatch: expected %0d, got %0d", exp_bit, got);
        errors++;
      end
    endfunction

    function int pending();
      return overlap_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sobb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  bit idle_on = 1'b1;
  int idle_cycles = 0;
  int box_cx, box_cy, box_cz, box_scale;

  overlap_scoreboard sb = new();

  sobb_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
  sobb_out_if out_ch();

  sphere_obb_overlap_test_top #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.overlaps);
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] clip_coord(int v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  function automatic int rand_span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic sphere_t sphere_at(int x, int y, int z, int r);
    sphere_t s;
    s.x = clip_coord(x);
    s.y = clip_coord(y);
    s.z = clip_coord(z);
    s.radius = RADIUS_BITS'((r > RADIUS_MAX) ? RADIUS_MAX : r);
    return s;
  endfunction

  task automatic send_sphere(input sphere_t s);
    while (idle_on && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sphere_x      <= s.x;
    in_ch.sphere_y      <= s.y;
    in_ch.sphere_z      <= s.z;
    in_ch.sphere_radius <= s.radius;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_sphere(s);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [sobb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic load_box(input int cx, cy, cz, input logic [CFG_W-1:0] ext,
                          input logic [sobb_pkg::AXIS_W-1:0] ax, ay, az);
    cfg_write(sobb_pkg::CFG_CENTER_X, CFG_W'(longint'(cx)));
    cfg_write(sobb_pkg::CFG_CENTER_Y, CFG_W'(longint'(cy)));
    cfg_write(sobb_pkg::CFG_CENTER_Z, CFG_W'(longint'(cz)));
    cfg_write(sobb_pkg::CFG_EXTENTS, ext);
    cfg_write(sobb_pkg::CFG_AXIS_X, CFG_W'(ax));
    cfg_write(sobb_pkg::CFG_AXIS_Y, CFG_W'(ay));
    cfg_write(sobb_pkg::CFG_AXIS_Z, CFG_W'(az));
    cfg_write(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_box(input axes_mode_e mode, input int scale, input ext_mode_e ext_mode);
    sobb_pkg::rot_t m[3][3];
    int perm[3];
    int k, tmp, lane;
    logic [CFG_W-1:0] ext;
    perm[0] = 0;
    perm[1] = 1;
    perm[2] = 2;
    k = $urandom_range(2);
    tmp = perm[2]; perm[2] = perm[k]; perm[k] = tmp;
    k = $urandom_range(1);
    tmp = perm[1]; perm[1] = perm[k]; perm[k] = tmp;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r][c] = '0;
        if (mode == AXES_IDENTITY && r == c) m[r][c] = sobb_pkg::rot_t'(16384);
      end
    end
    if (mode == AXES_PERMUTED || mode == AXES_PERTURBED) begin
      for (int c = 0; c < 3; c++) begin
        m[perm[c]][c] = sobb_pkg::rot_t'($urandom_range(1) ? 16384 : -16384);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (mode == AXES_PERTURBED) begin
          m[r][c] = sobb_pkg::rot_t'(int'(m[r][c]) + rand_span(48));
        end
        if (mode == AXES_RANDOM) m[r][c] = sobb_pkg::rot_t'($urandom);
      end
    end
    box_scale = scale;
    box_cx = int'(clip_coord(rand_span(1 << (scale + 2))));
    box_cy = int'(clip_coord(rand_span(1 << (scale + 2))));
    box_cz = int'(clip_coord(rand_span(1 << (scale + 2))));
    for (int i = 0; i < 3; i++) begin
      lane = $urandom_range(0, 1 << scale);
      if (lane > 1048575) lane = 1048575;
      ext[COORD_BITS*i +: COORD_BITS] = COORD_BITS'(lane);
    end
    if (ext_mode == EXT_ZERO) ext = '0;
    if (ext_mode == EXT_FULL) begin
      ext = '1;
      box_cx = COORD_MAX;
      box_cy = COORD_MIN;
      box_cz = COORD_MAX;
    end
    load_box(box_cx, box_cy, box_cz, ext,
             {m[2][0], m[1][0], m[0][0]},
             {m[2][1], m[1][1], m[0][1]},
             {m[2][2], m[1][2], m[0][2]});
  endtask

  task automatic send_random_sphere();
    int span, r;
    span = 3 << box_scale;
    if ($urandom_range(99) < 10) begin
      send_sphere(sphere_at(rand_span(COORD_MAX), rand_span(COORD_MAX), rand_span(COORD_MAX),
                            $urandom_range(0, RADIUS_MAX)));
    end else begin
      r = ($urandom_range(15) == 0) ? 0 : $urandom_range(0, 1 << box_scale);
      send_sphere(sphere_at(box_cx + rand_span(span), box_cy + rand_span(span),
                            box_cz + rand_span(span), r));
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.sphere_x      <= '0;
    in_ch.sphere_y      <= '0;
    in_ch.sphere_z      <= '0;
    in_ch.sphere_radius <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset box: zero extents at the origin
    send_sphere(sphere_at(0, 0, 0, 0));
    send_sphere(sphere_at(1, 0, 0, 0));
    drain_results();

    load_box(1024, 2048, -3072, {20'd1024, 20'd2048, 20'd4096},
             sobb_pkg::AXIS_X_RST, sobb_pkg::AXIS_Y_RST, sobb_pkg::AXIS_Z_RST);
    send_sphere(sphere_at(1024, 2048, -3072, 0));
    send_sphere(sphere_at(1024 + 4096 + 512, 2048, -3072, 512));
    send_sphere(sphere_at(1024 + 4096 + 513, 2048, -3072, 512));
    send_sphere(sphere_at(1024 - 4096 - 512, 2048, -3072, 512));
    send_sphere(sphere_at(1024 + 4096 + 300, 2048 + 2048 + 400, -3072, 500));
    send_sphere(sphere_at(1024 + 4096 + 300, 2048 + 2048 + 400, -3072, 499));
    send_sphere(sphere_at(1024 + 4096 + 2000, 2048, -3072, 100));
    send_sphere(sphere_at(1024, 2048, -3072 - 1024 - 257, 256));
    send_sphere(sphere_at(1024 + 4096, 0, -3072 + 1024, 0));
    send_sphere(sphere_at(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
    send_sphere(sphere_at(COORD_MIN, COORD_MIN, COORD_MIN, 0));
    send_sphere(sphere_at(COORD_MIN, COORD_MAX, 0, RADIUS_MAX));
    drain_results();

    load_box(COORD_MAX, COORD_MIN, 0, '1,
             {16'h8000, 16'h7FFF, 16'h0001},
             {16'h7FFF, 16'h8000, 16'h8000},
             {16'h0000, 16'hFFFF, 16'h7FFF});
    send_sphere(sphere_at(COORD_MIN, COORD_MAX, 0, RADIUS_MAX));
    send_sphere(sphere_at(COORD_MAX, COORD_MIN, 0, 0));
    send_sphere(sphere_at(0, 0, 0, 1));
    send_sphere(sphere_at(COORD_MIN, COORD_MIN, COORD_MAX, RADIUS_MAX));
    drain_results();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_on = (p != 4);
      randomize_box(axes_mode_e'(p % 4),
                    (p == N_PHASES - 1) ? 19 : int'($urandom_range(3, 17)),
                    (p == 1) ? EXT_ZERO : (p == N_PHASES - 2) ? EXT_FULL : EXT_RANDOM);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off the sender until the pipeline is empty
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
        send_random_sphere();
      end
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sobb_pkg.sv
rtl/sobb_if.sv
rtl/sobb_cfg.sv
rtl/sobb_fwd.sv
rtl/sobb_back.sv
rtl/sphere_obb_overlap_test_top.sv
rtl/sobb_chk.sv
test/sphere_obb_overlap_test_top_test.sv
